// File: rtl/glcd_pkg.sv
// Shared constants, control word type and microcode table for the pixel plot unit.
package glcd_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  localparam int X_W      = 7;
  localparam int Y_W      = 6;
  localparam int PAGE_W   = 3;
  localparam int ROW_W    = Y_W - PAGE_W;
  localparam int COL_W    = X_W - 1;
  localparam int ADDR_W   = PAGE_W + X_W;
  localparam int DEPTH    = 1 << ADDR_W;
  localparam int BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] CMD_COLUMN     = 8'h40;
  localparam logic [BYTE_W-1:0] CMD_PAGE       = 8'hB8;
  localparam logic [BYTE_W-1:0] CMD_START_LINE = 8'hC0;

  localparam int NUM_STEPS = 9;
  localparam int PC_W      = 4;

  // Chip select source
  localparam logic [1:0] CS_LEFT  = 2'd0;
  localparam logic [1:0] CS_RIGHT = 2'd1;
  localparam logic [1:0] CS_PIXEL = 2'd2;

  // Bus byte source
  localparam logic [2:0] BY_COLUMN0  = 3'd0;
  localparam logic [2:0] BY_PAGE     = 3'd1;
  localparam logic [2:0] BY_START    = 3'd2;
  localparam logic [2:0] BY_COLUMN_X = 3'd3;
  localparam logic [2:0] BY_DATA     = 3'd4;

  typedef struct packed {
    logic       is_data;
    logic [1:0] cs_sel;
    logic [2:0] byte_sel;
    logic       mem_rd;
    logic       mem_wr;
    logic       last;
    logic       done;
  } ucw_t;

  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '0;
    case (pc)
      4'd0: begin
        w.cs_sel = CS_LEFT;  w.byte_sel = BY_COLUMN0; w.mem_rd = 1'b1;
      end
      4'd1: begin
        w.cs_sel = CS_LEFT;  w.byte_sel = BY_PAGE;    w.mem_wr = 1'b1;
      end
      4'd2: begin
        w.cs_sel = CS_LEFT;  w.byte_sel = BY_START;
      end
      4'd3: begin
        w.cs_sel = CS_RIGHT; w.byte_sel = BY_COLUMN0;
      end
      4'd4: begin
        w.cs_sel = CS_RIGHT; w.byte_sel = BY_PAGE;
      end
      4'd5: begin
        w.cs_sel = CS_RIGHT; w.byte_sel = BY_START;
      end
      4'd6: begin
        w.cs_sel = CS_PIXEL; w.byte_sel = BY_COLUMN_X;
      end
      4'd7: begin
        w.cs_sel = CS_PIXEL; w.byte_sel = BY_PAGE;
      end
      4'd8: begin
        w.is_data = 1'b1; w.cs_sel = CS_PIXEL; w.byte_sel = BY_DATA;
        w.last = 1'b1;    w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/glcd_ifs.sv
// Request channel interfaces for pixel input and display bus output.
interface glcd_pix_if import glcd_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [X_W-1:0] pixel_x;
  logic [Y_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface glcd_bus_if import glcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_data;
  logic              chip_select;
  logic [BYTE_W-1:0] bus_byte;
  logic              last;

  modport source (output valid, output is_data, output chip_select, output bus_byte,
                  output last, input ready);
  modport sink   (input valid, input is_data, input chip_select, input bus_byte,
                  input last, output ready);
endinterface

// File: rtl/glcd_seq.sv
// Microcode sequencer: step counter, table lookup and end-of-program jump.
module glcd_seq import glcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic advance,
  output logic busy,
  output ucw_t ucw
);

  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;

  assign ucw  = ucode_rom(pc_r);
  assign busy = busy_r;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (busy_r && advance) begin
      if (ucw.done) begin
        busy_nxt = 1'b0;
        pc_nxt   = '0;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
    // a new request may enter on the cycle the last step retires
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

endmodule

// File: rtl/glcd_shadow_ram.sv
// Shadow frame store with registered read and a clearing sweep after reset.
module glcd_shadow_ram import glcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [BYTE_W-1:0] wdata,
  output logic [BYTE_W-1:0] rd_data,
  output logic              clearing
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (&clr_addr_r) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) rd_data_r <= mem[addr];
  end

endmodule

// File: rtl/glcd_pixel_plot_shadow_unit.sv
// Top level: pixel capture, microcoded datapath, shadow store and output register.
// An accepted pixel starts the sequencer; each bus write is then presented from the output register.
// Throughput: nine bus writes per pixel, set by the nine-step program, one per cycle while the
//   output is not stalled; a new pixel is taken as the last step retires.
// Off-screen pixels are accepted and dropped with no writes.
// Reset: synchronous active low; all 1024 store entries are swept to zero, no input taken.
module glcd_pixel_plot_shadow_unit import glcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  glcd_pix_if.sink   in_ch,
  glcd_bus_if.source out_ch
);

  logic [X_W-1:0]    x_r;
  logic [Y_W-1:0]    y_r;
  logic [BYTE_W-1:0] byte_r;

  logic              out_valid_r;
  logic              is_data_r;
  logic              chip_r;
  logic [BYTE_W-1:0] bus_byte_r;
  logic              last_r;

  logic              busy, clearing, advance, accept, on_screen, start;
  ucw_t              ucw;
  logic [PAGE_W-1:0] page;
  logic [ADDR_W-1:0] addr;
  logic [BYTE_W-1:0] rd_data, wdata, sel_byte;
  logic              sel_chip;

  assign advance  = busy && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !clearing && (!busy || (advance && ucw.done));
  assign accept   = in_ch.valid && in_ch.ready;
  assign on_screen = ({1'b0, in_ch.pixel_x} < (X_W+1)'(SCREEN_WIDTH)) &&
                     ({1'b0, in_ch.pixel_y} < (Y_W+1)'(SCREEN_HEIGHT));
  assign start    = accept && on_screen;

  assign page  = y_r[Y_W-1:ROW_W];
  assign addr  = {page, x_r};
  assign wdata = rd_data | (BYTE_W'(1) << y_r[ROW_W-1:0]);

  glcd_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .advance (advance),
    .busy    (busy),
    .ucw     (ucw)
  );

  glcd_shadow_ram u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (advance && ucw.mem_rd),
    .wr_en    (advance && ucw.mem_wr),
    .addr     (addr),
    .wdata    (wdata),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  always_comb begin
    case (ucw.cs_sel)
      CS_LEFT:  sel_chip = 1'b0;
      CS_RIGHT: sel_chip = 1'b1;
      CS_PIXEL: sel_chip = x_r[X_W-1];
      default:  sel_chip = 1'b0;
    endcase
    case (ucw.byte_sel)
      BY_COLUMN0:  sel_byte = CMD_COLUMN;
      BY_PAGE:     sel_byte = CMD_PAGE | BYTE_W'(page);
      BY_START:    sel_byte = CMD_START_LINE;
      BY_COLUMN_X: sel_byte = CMD_COLUMN | BYTE_W'(x_r[COL_W-1:0]);
      BY_DATA:     sel_byte = byte_r;
      default:     sel_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= in_ch.pixel_x;
      y_r <= in_ch.pixel_y;
    end
    // hold the updated byte for the data write
    if (advance && ucw.mem_wr) byte_r <= wdata;
    if (advance) begin
      is_data_r  <= ucw.is_data;
      chip_r     <= sel_chip;
      bus_byte_r <= sel_byte;
      last_r     <= ucw.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_data     = is_data_r;
  assign out_ch.chip_select = chip_r;
  assign out_ch.bus_byte    = bus_byte_r;
  assign out_ch.last        = last_r;

endmodule

// File: dv/tb_glcd_pixel_plot_shadow_unit.sv
`timescale 1ns / 100ps
// Testbench for the pixel plot unit: shadow store prediction and bus write checks.
module tb_glcd_pixel_plot_shadow_unit;
  import glcd_pkg::*;

  typedef struct packed {
    logic              is_data;
    logic              chip_select;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;
  } bus_write_t;

  // Holds the shadow frame and the bus writes still owed by the block.
  class bus_write_scoreboard;
    logic [BYTE_W-1:0] shadow_bytes [DEPTH];
    bus_write_t        due_writes [$];
    int                n_errors;
    int                n_writes;

    function new();
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      n_errors = 0;
      n_writes = 0;
    endfunction

    function void push_write(logic is_data, logic chip, logic [BYTE_W-1:0] byte_val,
                             logic last);
      bus_write_t w;
      w.is_data     = is_data;
      w.chip_select = chip;
      w.bus_byte    = byte_val;
      w.last        = last;
      due_writes.push_back(w);
    endfunction

    function void note_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      logic [PAGE_W-1:0] page;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] page_cmd;
      logic              chip;
      // drop pixels off the screen: no store update, no writes
      if (int'(x) >= SCREEN_WIDTH || int'(y) >= SCREEN_HEIGHT) return;
      page     = y[Y_W-1:ROW_W];
      addr     = {page, x};
      chip     = x[X_W-1];
      page_cmd = CMD_PAGE | BYTE_W'(page);
      shadow_bytes[addr] = shadow_bytes[addr] | (BYTE_W'(1) << y[ROW_W-1:0]);
      for (int c = 0; c < 2; c++) begin
        push_write(1'b0, c[0], CMD_COLUMN, 1'b0);
        push_write(1'b0, c[0], page_cmd, 1'b0);
        push_write(1'b0, c[0], CMD_START_LINE, 1'b0);
      end
      push_write(1'b0, chip, CMD_COLUMN | BYTE_W'(x[COL_W-1:0]), 1'b0);
      push_write(1'b0, chip, page_cmd, 1'b0);
      push_write(1'b1, chip, shadow_bytes[addr], 1'b1);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      n_errors++;
    endtask

    task check_write(bus_write_t got);
      bus_write_t want;
      n_writes++;
      if (due_writes.size() == 0) begin
        report($sformatf("write %0d with nothing due (rs=%0b cs=%0b byte=%02h last=%0b)",
                         n_writes, got.is_data, got.chip_select, got.bus_byte, got.last));
        return;
      end
      want = due_writes.pop_front();
      if (got.is_data !== want.is_data)
        report($sformatf("write %0d is_data %0b, want %0b", n_writes, got.is_data,
                         want.is_data));
      if (got.chip_select !== want.chip_select)
        report($sformatf("write %0d chip_select %0b, want %0b", n_writes,
                         got.chip_select, want.chip_select));
      if (got.bus_byte !== want.bus_byte)
        report($sformatf("write %0d bus_byte %02h, want %02h", n_writes, got.bus_byte,
                         want.bus_byte));
      if (got.last !== want.last)
        report($sformatf("write %0d last %0b, want %0b", n_writes, got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   src_calm;
  bit   sink_calm;
  int   sink_stall_left;
  int   sink_mode_left;

  glcd_pix_if in_ch ();
  glcd_bus_if out_ch ();

  bus_write_scoreboard sb = new();

  glcd_pixel_plot_shadow_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
    int gap;
    gap = (src_calm || $urandom_range(0, 2) != 0) ? 0 : pick_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pixel_x <= x;
    in_ch.pixel_y <= y;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  // Sink side: random stalls, with calm stretches where ready stays high.
  always @(negedge clk) begin
    if (sink_mode_left == 0) begin
      sink_calm      = ($urandom_range(0, 3) == 0);
      sink_mode_left = $urandom_range(50, 300);
    end else begin
      sink_mode_left--;
    end
    if (sink_stall_left > 0) begin
      sink_stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
      sink_stall_left = pick_idle() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_pixel(in_ch.pixel_x, in_ch.pixel_y);
  end

  always @(posedge clk) begin
    bus_write_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.is_data     = out_ch.is_data;
      got.chip_select = out_ch.chip_select;
      got.bus_byte    = out_ch.bus_byte;
      got.last        = out_ch.last;
      sb.check_write(got);
    end
  end

  initial begin
    logic [X_W-1:0] hot_x;
    logic [PAGE_W-1:0] hot_page;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.pixel_x   = '0;
    in_ch.pixel_y   = '0;
    out_ch.ready    = 1'b0;
    src_calm        = 1'b0;
    sink_calm       = 1'b0;
    sink_stall_left = 0;
    sink_mode_left  = 0;
    hot_x           = '0;
    hot_page        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners, both halves, the seam between controllers, alternating bit patterns
    send_pixel(7'd0, 6'd0);
    send_pixel(7'd127, 6'd63);
    send_pixel(7'd63, 6'd7);
    send_pixel(7'd64, 6'd8);
    send_pixel(7'd0, 6'd63);
    send_pixel(7'd127, 6'd0);
    send_pixel(7'd85, 6'd42);
    send_pixel(7'd42, 6'd21);
    send_pixel(7'd64, 6'd56);
    send_pixel(7'd63, 6'd63);
    // pixel already set: same writes again
    send_pixel(7'd0, 6'd0);
    // fill every row of one page so the byte reaches all ones
    for (int r = 1; r < 8; r++) send_pixel(7'd0, Y_W'(r));
    send_pixel(7'd0, 6'd5);

    for (int i = 0; i < 300; i++) begin
      if (i % 30 == 0) src_calm = ($urandom_range(0, 3) == 0);
      if (i % 20 == 0) begin
        hot_x    = X_W'($urandom_range(0, 127));
        hot_page = PAGE_W'($urandom_range(0, 7));
      end
      // keep hitting a few bytes so the store builds up multi-bit patterns
      if ($urandom_range(0, 9) < 6) begin
        x = hot_x + X_W'($urandom_range(0, 3));
        y = {hot_page, ROW_W'($urandom_range(0, 7))};
      end else begin
        x = X_W'($urandom_range(0, 127));
        y = Y_W'($urandom_range(0, 63));
      end
      send_pixel(x, y);
    end
    in_ch.valid <= 1'b0;

    while (sb.due_writes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
